// File: sv/mpfr_pkg.sv
// ----------------------------------------------------------------------------
// mpfr_pkg
// Shared types, constants and the CRC-16/Modbus byte update for the
// position frame receiver.
// ----------------------------------------------------------------------------
package mpfr_pkg;

    // frame record queue between the byte parser and the result stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // byte positions inside a response frame
    localparam logic [4:0] IDX_ADDR   = 5'd0;
    localparam logic [4:0] IDX_FUNC   = 5'd1;
    localparam logic [4:0] IDX_COUNT  = 5'd2;
    localparam logic [4:0] IDX_POS_HI = 5'd5;
    localparam logic [4:0] IDX_POS_LO = 5'd6;
    localparam logic [4:0] IDX_CRC_LO = 5'd7;
    localparam logic [4:0] IDX_CRC_HI = 5'd8;
    localparam logic [4:0] FRAME_LEN  = 5'd9;
    localparam logic [4:0] IDX_MAX    = 5'd31;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  FUNC_CODE  = 8'h03;
    localparam logic [7:0]  BYTE_COUNT = 8'h04;

    // configuration
    localparam logic       CFG_EXP_ADDR   = 1'b0;
    localparam logic       CFG_PASS_LIMIT = 1'b1;
    localparam logic [7:0] EXP_ADDR_RST   = 8'h01;
    localparam logic [7:0] PASS_LIMIT_RST = 8'd45;

    // angle scaling: raw * 360 / 1024
    localparam logic [24:0] ANG_NUM   = 25'd360;
    localparam int          ANG_SHIFT = 10;
    localparam logic [15:0] WRAP_HALF = 16'sd180;
    localparam logic [15:0] WRAP_FULL = 16'sd360;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_CRC = 2'd2,
        ST_HDR = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] pos;
    } t_rec;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/mpfr_front.sv
// ----------------------------------------------------------------------------
// mpfr_front
// Byte parser: counts bytes, runs the CRC, checks header and CRC bytes and
// emits one classified frame record on every frame end.
// ----------------------------------------------------------------------------
module mpfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_frame_end,
    input  logic [7:0]    i_exp_addr,
    output logic          o_rec_vld,
    output mpfr_pkg::t_rec o_rec
);
    import mpfr_pkg::*;

    logic [4:0]  r_idx,    n_idx;
    logic [15:0] r_crc,    n_crc;
    logic        r_hdr_ok, n_hdr_ok;
    logic        r_crc_ok, n_crc_ok;
    logic [15:0] r_pos,    n_pos;

    always_comb begin
        n_hdr_ok = r_hdr_ok;
        n_crc_ok = r_crc_ok;
        n_pos    = r_pos;
        case (r_idx)
            IDX_ADDR:   if (i_rx_byte != i_exp_addr)  n_hdr_ok = 1'b0;
            IDX_FUNC:   if (i_rx_byte != FUNC_CODE)   n_hdr_ok = 1'b0;
            IDX_COUNT:  if (i_rx_byte != BYTE_COUNT)  n_hdr_ok = 1'b0;
            IDX_POS_HI: n_pos = {i_rx_byte, r_pos[7:0]};
            IDX_POS_LO: n_pos = {r_pos[15:8], i_rx_byte};
            IDX_CRC_LO: if (i_rx_byte != r_crc[7:0])  n_crc_ok = 1'b0;
            IDX_CRC_HI: if (i_rx_byte != r_crc[15:8]) n_crc_ok = 1'b0;
            default: begin
            end
        endcase
        n_crc = (r_idx < IDX_CRC_LO) ? crc_feed(r_crc, i_rx_byte) : r_crc;
        n_idx = (r_idx < IDX_MAX) ? r_idx + 5'd1 : r_idx;
    end

    // classification, first failing check wins
    always_comb begin
        o_rec.pos = n_pos;
        if (n_idx != FRAME_LEN) begin
            o_rec.status = ST_LEN;
        end else if (!n_crc_ok) begin
            o_rec.status = ST_CRC;
        end else if (!n_hdr_ok) begin
            o_rec.status = ST_HDR;
        end else begin
            o_rec.status = ST_OK;
        end
    end

    assign o_rec_vld = i_vld && i_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_rec_vld) begin
            r_idx    <= '0;
            r_crc    <= CRC_INIT;
            r_hdr_ok <= 1'b1;
            r_crc_ok <= 1'b1;
            r_pos    <= '0;
        end else if (i_vld) begin
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_hdr_ok <= n_hdr_ok;
            r_crc_ok <= n_crc_ok;
            r_pos    <= n_pos;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_vld |=> (r_idx == '0 && r_crc == CRC_INIT && r_hdr_ok && r_crc_ok))
        else $error("frame state not cleared after frame end");
`endif

endmodule

// File: sv/mpfr_queue.sv
// ----------------------------------------------------------------------------
// mpfr_queue
// Short queue of frame records between the parser and the result stage.
// ----------------------------------------------------------------------------
module mpfr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mpfr_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_vld,
    output mpfr_pkg::t_rec o_rec,
    input  logic           i_pop
);
    import mpfr_pkg::*;

    t_rec            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;
    logic            push_en;
    logic            pop_en;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_en) r_wp <= r_wp + QAW'(1);
            if (pop_en)  r_rp <= r_rp + QAW'(1);
            case ({push_en, pop_en})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != QCW'(QDEPTH)) |-> (QAW'(r_wp - r_rp) == r_cnt[QAW-1:0]))
        else $error("queue count and pointers disagree");
`endif

endmodule

// File: sv/mpfr_back.sv
// ----------------------------------------------------------------------------
// mpfr_back
// Result stage: keeps the last good position, scales it to degrees,
// wraps and clamps the signed angle, and holds the result word.
// ----------------------------------------------------------------------------
module mpfr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  mpfr_pkg::t_rec        i_rec,
    output logic                  o_take,
    input  logic [7:0]            i_pass_limit,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [1:0]            o_status,
    output logic [15:0]           o_raw_position,
    output logic [14:0]           o_angle,
    output logic signed [8:0]     o_pass_value
);
    import mpfr_pkg::*;

    logic               r_out_vld;
    logic [15:0]        r_held;
    logic [15:0]        n_held;
    logic [1:0]         r_status;
    logic [14:0]        r_angle;
    logic signed [8:0]  r_pass;
    logic [24:0]        prod;
    logic [14:0]        angle;
    logic signed [15:0] wrapped;
    logic signed [15:0] lim;
    logic signed [15:0] clamped;
    logic               rec_ok;

    assign o_take = i_vld && (!r_out_vld || i_pop);
    assign rec_ok = (i_rec.status == ST_OK);
    assign n_held = rec_ok ? i_rec.pos : r_held;

    always_comb begin
        prod    = 25'(n_held) * ANG_NUM;
        angle   = prod[24:ANG_SHIFT];
        wrapped = (16'(angle) < WRAP_HALF) ? signed'(16'(angle))
                                           : signed'(16'(angle) - WRAP_FULL);
        lim     = signed'(16'(i_pass_limit));
        if (wrapped > lim) begin
            clamped = lim;
        end else if (wrapped < -lim) begin
            clamped = -lim;
        end else begin
            clamped = wrapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_held    <= '0;
        end else if (o_take) begin
            r_out_vld <= 1'b1;
            r_held    <= n_held;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_status <= i_rec.status;
            r_angle  <= angle;
            r_pass   <= clamped[8:0];
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_status       = r_status;
    assign o_raw_position = r_held;
    assign o_angle        = r_angle;
    assign o_pass_value   = r_pass;

`ifndef NO_ASSERTIONS
    a_held_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_take && rec_ok) |=> $stable(r_held))
        else $error("held position changed without a good frame");
    a_clamp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (clamped <= lim && clamped >= -lim))
        else $error("signed angle outside the clamp");
`endif

endmodule

// File: sv/modbus_position_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// modbus_position_frame_receiver_unit
// Receives encoder response frames byte by byte, checks length, CRC and
// header, and delivers status, held position and scaled angles per frame.
// ----------------------------------------------------------------------------
//  channel   handshake       payload
//  input     push / full     i_rx_byte, i_frame_end
//  result    empty / pop     o_status, o_raw_position, o_angle, o_pass_value
//  config    i_cfg_we        i_cfg_idx, i_cfg_wdata
//
//  one byte word accepted per cycle, back to back, while full is low; a frame
//  end's record passes the record queue into the result register once it is free.
//  the CRC update is unrolled over the byte and scaling is one constant multiply.
//  full rises when the four-entry record queue fills, only while pop is held low.
//  synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module modbus_position_frame_receiver_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_frame_end,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_status,
    output logic [15:0]       o_raw_position,
    output logic [14:0]       o_angle,
    output logic signed [8:0] o_pass_value,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [7:0]        i_cfg_wdata
);
    import mpfr_pkg::*;

    logic [7:0] r_exp_addr;
    logic [7:0] r_pass_limit;
    logic       in_vld;
    logic       rec_push;
    t_rec       rec_in;
    logic       q_vld;
    t_rec       q_rec;
    logic       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr   <= EXP_ADDR_RST;
            r_pass_limit <= PASS_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXP_ADDR:   r_exp_addr   <= i_cfg_wdata;
                CFG_PASS_LIMIT: r_pass_limit <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign in_vld = push && !full;

    mpfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (in_vld),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .i_exp_addr  (r_exp_addr),
        .o_rec_vld   (rec_push),
        .o_rec       (rec_in)
    );

    mpfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec_in),
        .o_full  (full),
        .o_vld   (q_vld),
        .o_rec   (q_rec),
        .i_pop   (q_pop)
    );

    mpfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vld          (q_vld),
        .i_rec          (q_rec),
        .o_take         (q_pop),
        .i_pass_limit   (r_pass_limit),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_status       (o_status),
        .o_raw_position (o_raw_position),
        .o_angle        (o_angle),
        .o_pass_value   (o_pass_value)
    );

endmodule

// File: tb/tb_modbus_position_frame_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_position_frame_receiver_unit
// Drives encoder response frames into the receiver byte by byte and checks
// every frame report against a local model of the length, CRC and header
// checks and the angle scaling. A short table of directed bytes comes first,
// then six phases of random frames under different register settings and
// handshake idling, one of them with a long stall on the result side.
// ----------------------------------------------------------------------------
module tb_modbus_position_frame_receiver_unit;
    import mpfr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 300;
    localparam int STALL_CYCLES = 400;

    typedef struct packed {
        t_status            status;
        logic [15:0]        raw;
        logic [14:0]        angle;
        logic signed [8:0]  pass_value;
    } report_t;

    // where a directed byte comes from
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_BAD
    } byte_src_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        byte_src_t  src;
        logic       typed;
        report_t    rep;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic [7:0]        rx_byte = 8'h00;
    logic              frame_end = 1'b0;
    logic              pop = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_idx = 1'b0;
    logic [7:0]        cfg_wdata = 8'h00;
    logic              o_full;
    logic              o_empty;
    logic [1:0]        o_status;
    logic [15:0]       o_raw_position;
    logic [14:0]       o_angle;
    logic signed [8:0] o_pass_value;

    // local copy of the receiver state and registers
    logic [4:0]  pr_index;
    logic [15:0] pr_crc;
    logic        pr_hdr_ok;
    logic        pr_crc_ok;
    logic [15:0] pr_pos;
    logic [15:0] pr_held;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_limit;

    report_t  expected_reports[$];
    dir_row_t dir_rows[$];

    int err_cnt = 0;
    int cycle_cnt = 0;
    int phase_words = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    modbus_position_frame_receiver_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (o_full),
        .i_rx_byte      (rx_byte),
        .i_frame_end    (frame_end),
        .empty          (o_empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_raw_position (o_raw_position),
        .o_angle        (o_angle),
        .o_pass_value   (o_pass_value),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // bit-serial CRC-16/Modbus, data bits folded in at the feedback point
    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] c,
                                                      input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ d[k];
            c = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic dir_row_t drow(input logic [7:0] data, input logic last,
                                      input byte_src_t src = SRC_DATA,
                                      input logic typed = 1'b0,
                                      input t_status st = ST_OK,
                                      input logic [15:0] raw = 16'h0000,
                                      input logic [14:0] ang = 15'd0,
                                      input logic signed [8:0] pv = 9'sd0);
        dir_row_t r;
        r.data = data;
        r.last = last;
        r.src = src;
        r.typed = typed;
        r.rep.status = st;
        r.rep.raw = raw;
        r.rep.angle = ang;
        r.rep.pass_value = pv;
        return r;
    endfunction

    task automatic frame_clear();
        pr_index = 5'd0;
        pr_crc = CRC_INIT;
        pr_hdr_ok = 1'b1;
        pr_crc_ok = 1'b1;
        pr_pos = 16'h0000;
    endtask

    // advances the frame checker by one byte; got is set on a frame end
    task automatic frame_check_step(input logic [7:0] b, input logic last,
                                    output logic got, output report_t rep);
        logic [4:0] i;
        int unsigned ang;
        int s;
        int lim;
        i = pr_index;
        case (i)
            IDX_ADDR:   if (b != reg_addr) pr_hdr_ok = 1'b0;
            IDX_FUNC:   if (b != FUNC_CODE) pr_hdr_ok = 1'b0;
            IDX_COUNT:  if (b != BYTE_COUNT) pr_hdr_ok = 1'b0;
            IDX_POS_HI: pr_pos[15:8] = b;
            IDX_POS_LO: pr_pos[7:0] = b;
            IDX_CRC_LO: if (b != pr_crc[7:0]) pr_crc_ok = 1'b0;
            IDX_CRC_HI: if (b != pr_crc[15:8]) pr_crc_ok = 1'b0;
            default: ;
        endcase
        if (i < IDX_CRC_LO) begin
            pr_crc = crc16_modbus_byte(pr_crc, b);
        end
        if (i != IDX_MAX) begin
            pr_index = i + 5'd1;
        end
        got = last;
        rep = '0;
        if (last) begin
            if (pr_index != FRAME_LEN) begin
                rep.status = ST_LEN;
            end else if (!pr_crc_ok) begin
                rep.status = ST_CRC;
            end else if (!pr_hdr_ok) begin
                rep.status = ST_HDR;
            end else begin
                rep.status = ST_OK;
                pr_held = pr_pos;
            end
            ang = (32'(pr_held) * 360) / 1024;
            s = (ang < 180) ? int'(ang) : int'(ang) - 360;
            lim = int'(reg_limit);
            if (s > lim) begin
                s = lim;
            end else if (s < -lim) begin
                s = -lim;
            end
            rep.raw = pr_held;
            rep.angle = ang[14:0];
            rep.pass_value = s[8:0];
            frame_clear();
        end
    endtask

    // offers one word, waits for it to be taken, then runs it through the model
    task automatic send_word(input logic [7:0] b, input logic last,
                             output logic got, output report_t rep);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        frame_end <= last;
        do @(posedge clk); while (o_full);
        phase_words++;
        frame_check_step(b, last, got, rep);
    endtask

    task automatic send_frame();
        int style;
        int len;
        int bad_at;
        logic [7:0] b;
        logic [7:0] flip;
        logic [15:0] raw;
        logic got;
        report_t rep;
        style = $urandom_range(99);
        len = 9;
        bad_at = -1;
        flip = 8'($urandom_range(1, 255));
        case ($urandom_range(4))
            0: raw = 16'($urandom_range(1023));
            1: raw = 16'($urandom);
            2: raw = 16'($urandom_range(2047));
            3: begin
                case ($urandom_range(5))
                    0: raw = 16'd0;
                    1: raw = 16'd511;
                    2: raw = 16'd512;
                    3: raw = 16'd1023;
                    4: raw = 16'd1024;
                    default: raw = 16'hFFFF;
                endcase
            end
            default: raw = 16'(508 + $urandom_range(8));
        endcase
        if (style >= 86) begin
            case ($urandom_range(3))
                0: len = $urandom_range(10, 16);
                1: len = $urandom_range(28, 40);
                default: len = $urandom_range(1, 8);
            endcase
        end else if (style >= 76) begin
            bad_at = $urandom_range(7, 8);
        end else if (style >= 66) begin
            bad_at = $urandom_range(2);
        end
        for (int i = 0; i < len; i++) begin
            if (style >= 86) begin
                b = 8'($urandom);
            end else begin
                case (i)
                    IDX_ADDR:   b = reg_addr;
                    IDX_FUNC:   b = FUNC_CODE;
                    IDX_COUNT:  b = BYTE_COUNT;
                    IDX_POS_HI: b = raw[15:8];
                    IDX_POS_LO: b = raw[7:0];
                    IDX_CRC_LO: b = pr_crc[7:0];
                    IDX_CRC_HI: b = pr_crc[15:8];
                    default:    b = 8'($urandom);
                endcase
            end
            if (i == bad_at) begin
                b = b ^ flip;
            end
            send_word(b, i == len - 1, got, rep);
            if (got) begin
                expected_reports.push_back(rep);
            end
        end
    endtask

    // stop offering and wait until every report is back and the pipe is quiet
    task automatic settle();
        push <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] addr, input logic [7:0] limit);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_EXP_ADDR;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_idx <= CFG_PASS_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_addr = addr;
        reg_limit = limit;
    endtask

    task automatic take_report();
        report_t want;
        if (expected_reports.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) begin
                $display("unexpected word: status %0d raw %h angle %0d pass %0d",
                         o_status, o_raw_position, o_angle, o_pass_value);
            end
            return;
        end
        want = expected_reports.pop_front();
        if (o_status !== want.status || o_raw_position !== want.raw ||
            o_angle !== want.angle || o_pass_value !== want.pass_value) begin
            err_cnt++;
            if (err_cnt <= 10) begin
                $display("mismatch: status %0d/%0d raw %h/%h angle %0d/%0d pass %0d/%0d",
                         o_status, want.status, o_raw_position, want.raw,
                         o_angle, want.angle, o_pass_value, want.pass_value);
            end
        end
    endtask

    // result side: checks taken words and decides pop for the next edge
    always @(posedge clk) begin
        if (pop && !o_empty) begin
            take_report();
        end
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            pop <= 1'b0;
            hold_left <= STALL_CYCLES;
            hold_done <= 1'b1;
        end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        logic got;
        report_t rep;
        logic [7:0] b;

        reg_addr = EXP_ADDR_RST;
        reg_limit = PASS_LIMIT_RST;
        pr_held = 16'h0000;
        frame_clear();

        // single byte right after reset
        dir_rows.push_back(drow(8'h00, 1'b1, SRC_DATA, 1'b1, ST_LEN));
        // good frame with the largest position
        dir_rows.push_back(drow(8'h01, 1'b0));
        dir_rows.push_back(drow(8'h03, 1'b0));
        dir_rows.push_back(drow(8'h04, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'hFF, 1'b0));
        dir_rows.push_back(drow(8'hFF, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0, SRC_CRC_LO));
        dir_rows.push_back(drow(8'h00, 1'b1, SRC_CRC_HI, 1'b1, ST_OK, 16'hFFFF,
                                15'd23039, 9'sd45));
        // bad header and bad crc together: crc wins, position held
        dir_rows.push_back(drow(8'hFF, 1'b0));
        dir_rows.push_back(drow(8'hFF, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b0, SRC_CRC_BAD));
        dir_rows.push_back(drow(8'h00, 1'b1, SRC_CRC_HI, 1'b1, ST_CRC, 16'hFFFF,
                                15'd23039, 9'sd45));
        // short frame
        dir_rows.push_back(drow(8'hFF, 1'b0));
        dir_rows.push_back(drow(8'h00, 1'b1, SRC_DATA, 1'b1, ST_LEN, 16'hFFFF,
                                15'd23039, 9'sd45));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 28;
        rx_idle_pct = 45;
        foreach (dir_rows[n]) begin
            case (dir_rows[n].src)
                SRC_CRC_LO:  b = pr_crc[7:0];
                SRC_CRC_HI:  b = pr_crc[15:8];
                SRC_CRC_BAD: b = ~pr_crc[7:0];
                default:     b = dir_rows[n].data;
            endcase
            send_word(b, dir_rows[n].last, got, rep);
            if (got) begin
                expected_reports.push_back(dir_rows[n].typed ? dir_rows[n].rep : rep);
            end
        end

        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: set_regs(8'h00, 8'd0);
                1: set_regs(8'hFF, 8'd255);
                2: set_regs(8'($urandom), 8'd180);
                3: set_regs(8'($urandom), 8'($urandom));
                4: set_regs(EXP_ADDR_RST, PASS_LIMIT_RST);
                default: set_regs(8'($urandom), 8'd1);
            endcase
            if (p < 2) begin
                tx_idle_pct = 28;
                rx_idle_pct = 45;
            end else if (p < 4) begin
                tx_idle_pct = 45;
                rx_idle_pct = 28;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long result-side stall while frames keep coming
            if (p == 1) begin
                hold_req = 1'b1;
            end
            phase_words = 0;
            while (phase_words < PHASE_WORDS) send_frame();
        end

        settle();
        if (err_cnt == 0 && expected_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
